[rtl/fmbs_pkg.sv]
// fmbs_pkg: shared constants, payload structs and control structs for the
// FM-index backward search block. No dependencies.
package fmbs_pkg;

	localparam int TEXT_DEPTH   = 4096;
	localparam int ALPHABET_MAX = 8;

	localparam int POS_W    = $clog2(TEXT_DEPTH);
	localparam int CNT_W    = 13;
	localparam int SYM_W    = 3;
	localparam int ACT_W    = 2;
	localparam int ALPHA_W  = 4;
	localparam int CIDX_W   = $clog2(ALPHABET_MAX);
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [ACT_W-1:0] ACT_BWT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CUM_WRITE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SEARCH    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 1'd1;

	typedef logic [SYM_W-1:0] sym_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		pos_t             position;
		sym_t             symbol;
		cnt_t             count_value;
		logic             pattern_start;
	} fmbs_in_t;

	typedef struct packed {
		cnt_t range_begin;
		cnt_t range_end;
		logic no_match;
	} fmbs_out_t;

	// BWT store write
	typedef struct packed {
		logic en;
		pos_t addr;
		sym_t sym;
	} bwt_wr_t;

	// rank scan request / response
	typedef struct packed {
		logic start;
		sym_t sym;
		cnt_t lim_b;
		cnt_t lim_e;
	} rank_req_t;

	typedef struct packed {
		logic done;
		cnt_t cnt_b;
		cnt_t cnt_e;
	} rank_rsp_t;

endpackage

[rtl/fmbs_rank_unit.sv]
// fmbs_rank_unit: BWT symbol store and the sequential rank counter.
// Depends on fmbs_pkg.
module fmbs_rank_unit
	import fmbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  bwt_wr_t   wr,
	input  rank_req_t req,
	output rank_rsp_t rsp
);

	logic [SYM_W-1:0] mem [TEXT_DEPTH];

	logic busy_q;
	cnt_t addr_q;
	cnt_t lim_q;
	cnt_t lim_b_q;
	cnt_t lim_e_q;
	sym_t sym_q;
	cnt_t cnt_b_q;
	cnt_t cnt_e_q;
	logic done_q;
	logic rd_valid_s1;
	cnt_t idx_s1;
	sym_t rdata_s1;

	logic issue;
	logic hit;

	assign issue = busy_q && (addr_q < lim_q);
	assign hit   = rd_valid_s1 && (rdata_s1 == sym_q);

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.sym;
		end
		rdata_s1 <= mem[addr_q[POS_W-1:0]];
		idx_s1   <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			addr_q      <= '0;
			lim_q       <= '0;
			lim_b_q     <= '0;
			lim_e_q     <= '0;
			sym_q       <= '0;
			cnt_b_q     <= '0;
			cnt_e_q     <= '0;
			done_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			rd_valid_s1 <= issue;
			if (req.start) begin
				busy_q  <= 1'b1;
				addr_q  <= '0;
				lim_b_q <= req.lim_b;
				lim_e_q <= req.lim_e;
				lim_q   <= (req.lim_b > req.lim_e) ? req.lim_b : req.lim_e;
				sym_q   <= req.sym;
				cnt_b_q <= '0;
				cnt_e_q <= '0;
			end else if (busy_q) begin
				if (issue) begin
					addr_q <= addr_q + 1'b1;
				end else if (!rd_valid_s1) begin
					// last read drained
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				if (hit && (idx_s1 < lim_b_q)) begin
					cnt_b_q <= cnt_b_q + 1'b1;
				end
				if (hit && (idx_s1 < lim_e_q)) begin
					cnt_e_q <= cnt_e_q + 1'b1;
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.cnt_b = cnt_b_q;
	assign rsp.cnt_e = cnt_e_q;

endmodule

[rtl/fm_index_backward_search.sv]
// fm_index_backward_search: top level, sequencer, count table and result register.
// Depends on fmbs_pkg and fmbs_rank_unit.

// FM-index backward search. Load the BWT with action 0 (one symbol per transfer) and the
// cumulative count table with action 1; both loads leave the block idle and ready for the
// next item. Then send pattern symbols last-to-first with action 2, pattern_start set on
// the first. Each search symbol gives one result with the current interval [range_begin,
// range_end) or a sticky no_match (range 0,0) until the next pattern start. A first
// symbol needs two count-table reads (cum[sym], then cum[sym+1]). For a later symbol both
// rank counts come from one sequential pass through the BWT store up to the larger of the
// two limits clipped to text_length, one symbol read per cycle, so the store's single
// read port sets the rate. in_ready is low while a search symbol is being worked on. The
// result register decouples the output: the next item is taken while a result still waits,
// but a new result is not produced until the previous one has transferred. Configuration
// writes are taken at any time and must only be issued while the block is idle.
module fm_index_backward_search
	import fmbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fmbs_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fmbs_out_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BASE = 3'd1; // cum[sym] arrives
	localparam logic [2:0] ST_END  = 3'd2; // cum[sym+1] arrives (pattern start)
	localparam logic [2:0] ST_SCAN = 3'd3; // rank pass running
	localparam logic [2:0] ST_OUT  = 3'd4; // load result register

	logic [2:0] state_q;

	// configuration
	cnt_t               text_length_q;
	logic [ALPHA_W-1:0] alphabet_size_q;
	cnt_t               len_eff;
	logic [ALPHA_W-1:0] alpha_eff;

	// search state
	cnt_t cur_begin_q;
	cnt_t cur_end_q;
	logic failed_q;
	sym_t sym_q;
	logic start_q;
	cnt_t base_q;

	// count table
	cnt_t              cum [ALPHABET_MAX];
	logic [CIDX_W-1:0] cum_raddr;
	cnt_t              cum_rd_q;

	logic      in_xfer;
	logic      sym_ok;
	logic      next_ok;
	cnt_t      end_sel;
	logic      out_free;
	bwt_wr_t   bwt_wr;
	rank_req_t rank_req;
	rank_rsp_t rank_rsp;

	logic [CNT_W:0] sum_b;
	logic [CNT_W:0] sum_e;
	cnt_t           nb;
	cnt_t           ne;

	fmbs_out_t out_q;
	logic      out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign len_eff   = (text_length_q > CNT_W'(TEXT_DEPTH)) ? CNT_W'(TEXT_DEPTH) : text_length_q;
	assign alpha_eff = (alphabet_size_q > ALPHA_W'(ALPHABET_MAX)) ?
		ALPHA_W'(ALPHABET_MAX) : alphabet_size_q;

	assign sym_ok  = {1'b0, sym_q} < alpha_eff;
	assign next_ok = ({1'b0, sym_q} + 4'd1) < alpha_eff;
	assign end_sel = next_ok ? cum_rd_q : len_eff;

	// rank + base, saturated to 13 bits
	assign sum_b = {1'b0, rank_rsp.cnt_b} + {1'b0, base_q};
	assign sum_e = {1'b0, rank_rsp.cnt_e} + {1'b0, base_q};
	assign nb    = sum_b[CNT_W] ? CNT_MAX : sum_b[CNT_W-1:0];
	assign ne    = sum_e[CNT_W] ? CNT_MAX : sum_e[CNT_W-1:0];

	// BWT load goes straight to the store
	assign bwt_wr.en   = in_xfer && (in_data.action == ACT_BWT_WRITE);
	assign bwt_wr.addr = in_data.position;
	assign bwt_wr.sym  = in_data.symbol;

	// scan limits are clipped to the loaded text length
	assign rank_req.start = (state_q == ST_BASE) && !start_q && !failed_q && sym_ok;
	assign rank_req.sym   = sym_q;
	assign rank_req.lim_b = (cur_begin_q < len_eff) ? cur_begin_q : len_eff;
	assign rank_req.lim_e = (cur_end_q < len_eff) ? cur_end_q : len_eff;

	fmbs_rank_unit u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (bwt_wr),
		.req    (rank_req),
		.rsp    (rank_rsp)
	);

	// count table: one write, one registered read per cycle
	always_comb begin
		if (state_q == ST_IDLE) begin
			cum_raddr = in_data.symbol;
		end else begin
			cum_raddr = sym_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (in_data.action == ACT_CUM_WRITE)) begin
			cum[in_data.symbol] <= in_data.count_value;
		end
		cum_rd_q <= cum[cum_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_length_q   <= CNT_W'(4096);
			alphabet_size_q <= ALPHA_W'(5);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TEXT_LENGTH:   text_length_q   <= cfg_data;
				CFG_ALPHABET_SIZE: alphabet_size_q <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_begin_q <= '0;
			cur_end_q   <= '0;
			failed_q    <= 1'b0;
			sym_q       <= '0;
			start_q     <= 1'b0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// a result leaving in the same cycle as the next one loads stays valid
			if (out_valid_q && out_ready && !((state_q == ST_OUT) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && (in_data.action == ACT_SEARCH)) begin
						sym_q   <= in_data.symbol;
						start_q <= in_data.pattern_start;
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					base_q <= cum_rd_q;
					if (start_q) begin
						if (sym_ok) begin
							state_q <= ST_END;
						end else begin
							failed_q    <= 1'b1;
							cur_begin_q <= '0;
							cur_end_q   <= '0;
							state_q     <= ST_OUT;
						end
					end else if (failed_q) begin
						// sticky: interval already 0,0
						state_q <= ST_OUT;
					end else if (!sym_ok) begin
						failed_q    <= 1'b1;
						cur_begin_q <= '0;
						cur_end_q   <= '0;
						state_q     <= ST_OUT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_END: begin
					if (base_q >= end_sel) begin
						failed_q    <= 1'b1;
						cur_begin_q <= '0;
						cur_end_q   <= '0;
					end else begin
						failed_q    <= 1'b0;
						cur_begin_q <= base_q;
						cur_end_q   <= end_sel;
					end
					state_q <= ST_OUT;
				end
				ST_SCAN: begin
					if (rank_rsp.done) begin
						if (nb >= ne) begin
							failed_q    <= 1'b1;
							cur_begin_q <= '0;
							cur_end_q   <= '0;
						end else begin
							cur_begin_q <= nb;
							cur_end_q   <= ne;
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q       <= 1'b1;
						out_q.range_begin <= cur_begin_q;
						out_q.range_end   <= cur_end_q;
						out_q.no_match    <= failed_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	// rank results only come back while the sequencer waits for them
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rank_rsp.done |-> (state_q == ST_SCAN))
		else $error("rank response outside scan state");

	// a no-match result always carries the empty interval
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.no_match) |->
			((out_data.range_begin == '0) && (out_data.range_end == '0)))
		else $error("no_match with non-zero range");

	// a live result is a non-empty interval
	a_live_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.no_match) |->
			(out_data.range_begin < out_data.range_end))
		else $error("empty interval reported as a match");

	// leaving the output state always presents a result
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && out_free) |=> out_valid)
		else $error("result not presented");
`endif

endmodule
